// File: src/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/rmv_pkg.sv
// Shared types and constants for the running statistics block
package rmv_pkg;

	localparam int DIV_NUM_W = 64;
	localparam int DIV_CNT_W = 7;
	localparam int VAR_W     = 40;
	localparam int RAD_W     = 48;
	localparam int ROOT_W    = 24;
	localparam int FRAC_W    = 16;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] iters;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MLOAD,
		ST_MDIV,
		ST_MULLOAD,
		ST_MUL,
		ST_ACC,
		ST_VLOAD,
		ST_VDIV,
		ST_SLOAD,
		ST_SQRT,
		ST_OUT
	} state_t;

endpackage

// File: src/rmv_div.sv
// Bit-serial restoring divider, one quotient bit per cycle
module rmv_div import rmv_pkg::*; #(
	parameter int DEN_W = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_ctl_t             ctl,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DEN_W-1:0]     den,
	output logic [DIV_NUM_W-1:0] quo,
	output div_sts_t             sts
);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DEN_W:0]       rem_t;
	logic                 fit;

	assign rem_t = {rem_q, num_q[DIV_NUM_W-1]};
	assign fit   = rem_t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			cnt_q  <= ctl.iters;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			// shift the quotient bit in as the dividend moves out
			num_q <= {num_q[DIV_NUM_W-2:0], fit};
			rem_q <= fit ? DEN_W'(rem_t - {1'b0, den_q}) : rem_t[DEN_W-1:0];
		end
	end

	assign quo      = num_q;
	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;

	`include "assert_macros.svh"

	`ASSERT_NXT(a_div_runs, clk, arst_n, ctl.start && ctl.iters != '0, sts.busy)
	`ASSERT_IMP(a_div_done_idle, clk, arst_n, sts.done, !sts.busy)
	`ASSERT_NXT(a_div_ends, clk, arst_n, sts.busy && cnt_q == DIV_CNT_W'(1) && !ctl.start,
		sts.done)

endmodule

// File: src/running_mean_variance_minmax.sv
// Welford running mean, variance, deviation, minimum and maximum (top level)
//
//  channel | signals                                        | word
//  in      | in_valid, in_ready, sample, restart            | one sample
//  out     | out_valid, out_ready, sample_count, running_mean,| one set of statistics
//          | sample_variance, std_deviation, minimum, maximum, saturated
//
// An ordinary sample runs the mean division and the product, one bit a cycle, then
// the variance division on the shared divider and the square root. A restart word
// skips both divisions and the product, a word at full count the mean division and
// the product. One word is in work at a time; the next is taken while the last
// result waits in the output register. Reset clears count, mean, sum, min and max.
module running_mean_variance_minmax import rmv_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [23:0]                  sample_count,
	output logic signed [31:0]           running_mean,
	output logic [VAR_W-1:0]             sample_variance,
	output logic [ROOT_W-1:0]            std_deviation,
	output logic signed [SAMPLE_BITS-1:0] minimum,
	output logic signed [SAMPLE_BITS-1:0] maximum,
	output logic                         saturated
);

	localparam int MAGW  = SAMPLE_BITS + FRAC_W;
	localparam int DW    = MAGW + 1;
	localparam int PW    = 2 * MAGW;
	localparam int CNT_W = $clog2(MAGW + 1);

	state_t state_q, state_d;

	logic [COUNT_BITS-1:0]      count_q;
	logic signed [MAGW-1:0]     mean_q;
	logic [DIV_NUM_W-1:0]       sum_q;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q;
	logic signed [MAGW-1:0]     bigx_q;
	logic signed [DW-1:0]       dold_q;
	logic                       sat_q;
	logic [MAGW-1:0]            a_q, b_q;
	logic [PW-1:0]              acc_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [VAR_W-1:0]           var_q;
	logic [RAD_W-1:0]           rad_q;
	logic [ROOT_W+1:0]          rem_q;
	logic [ROOT_W-1:0]          root_q;

	logic                       in_fire, out_load, fresh, full;
	logic signed [MAGW-1:0]     bigx_in;
	logic signed [DW-1:0]       dold_in, dnew;
	logic [MAGW-1:0]            mag_old, mag_new;
	logic [MAGW:0]              mul_sum;
	logic [DIV_NUM_W:0]         sum_ext;
	logic [ROOT_W+1:0]          rem_t, trial;
	logic                       sq_fit;

	div_ctl_t                   div_ctl;
	div_sts_t                   div_sts;
	logic [DIV_NUM_W-1:0]       div_num, div_quo;
	logic [COUNT_BITS-1:0]      div_den;

	assign in_fire = in_valid && in_ready;
	assign fresh   = restart || (count_q == '0);
	assign full    = (count_q == '1);
	assign bigx_in = {sample, {FRAC_W{1'b0}}};
	assign dold_in = DW'(bigx_in) - DW'(mean_q);
	assign mag_old = dold_q[DW-1] ? MAGW'(-dold_q) : MAGW'(dold_q);
	assign dnew    = DW'(bigx_q) - DW'(mean_q);
	assign mag_new = dnew[DW-1] ? MAGW'(-dnew) : MAGW'(dnew);
	assign mul_sum = {1'b0, acc_q[PW-1:MAGW]} + (b_q[0] ? {1'b0, a_q} : '0);
	assign sum_ext = {1'b0, sum_q} + {1'b0, DIV_NUM_W'(acc_q >> 24)};
	assign rem_t   = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial   = {root_q, 2'b01};
	assign sq_fit  = rem_t >= trial;

	rmv_div #(.DEN_W(COUNT_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.sts    (div_sts)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = (fresh || full) ? ST_VLOAD : ST_MLOAD;
			ST_MLOAD:   state_d = ST_MDIV;
			ST_MDIV:    if (div_sts.done) state_d = ST_MULLOAD;
			ST_MULLOAD: state_d = ST_MUL;
			ST_MUL:     if (cnt_q == CNT_W'(1)) state_d = ST_ACC;
			ST_ACC:     state_d = ST_VLOAD;
			ST_VLOAD:   state_d = (count_q > COUNT_BITS'(1)) ? ST_VDIV : ST_SLOAD;
			ST_VDIV:    if (div_sts.done) state_d = ST_SLOAD;
			ST_SLOAD:   state_d = ST_SQRT;
			ST_SQRT:    if (cnt_q == CNT_W'(1)) state_d = ST_OUT;
			ST_OUT:     if (!out_valid || out_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready      = 1'b0;
		out_load      = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.iters = DIV_CNT_W'(DIV_NUM_W);
		div_num       = sum_q;
		div_den       = count_q - 1'b1;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_MLOAD: begin
				div_ctl.start = 1'b1;
				div_ctl.iters = DIV_CNT_W'(MAGW);
				div_num       = {mag_old, {(DIV_NUM_W-MAGW){1'b0}}};
				div_den       = count_q;
			end
			ST_VLOAD: div_ctl.start = (count_q > COUNT_BITS'(1));
			ST_OUT:   out_load = !out_valid || out_ready;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			mean_q  <= '0;
			sum_q   <= '0;
			min_q   <= '0;
			max_q   <= '0;
			cnt_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_fire) begin
					if (fresh) begin
						count_q <= COUNT_BITS'(1);
						mean_q  <= bigx_in;
						sum_q   <= '0;
						min_q   <= sample;
						max_q   <= sample;
					end else if (!full) begin
						count_q <= count_q + 1'b1;
						if (sample < min_q) min_q <= sample;
						if (sample > max_q) max_q <= sample;
					end
				end
				ST_MDIV: if (div_sts.done) begin
					mean_q <= dold_q[DW-1] ? MAGW'(DW'(mean_q) - {1'b0, div_quo[MAGW-1:0]})
						: MAGW'(DW'(mean_q) + {1'b0, div_quo[MAGW-1:0]});
				end
				ST_MULLOAD: cnt_q <= CNT_W'(MAGW);
				ST_MUL:     cnt_q <= cnt_q - 1'b1;
				ST_ACC:     sum_q <= sum_ext[DIV_NUM_W] ? '1 : sum_ext[DIV_NUM_W-1:0];
				ST_SLOAD:   cnt_q <= CNT_W'(ROOT_W);
				ST_SQRT:    cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// datapath words, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_fire) begin
				bigx_q <= bigx_in;
				dold_q <= dold_in;
				sat_q  <= !fresh && full;
			end
			ST_MULLOAD: begin
				a_q   <= mag_old;
				b_q   <= mag_new;
				acc_q <= '0;
			end
			ST_MUL: begin
				// add the partial product on top, shift one bit down
				acc_q <= {mul_sum, acc_q[MAGW-1:1]};
				b_q   <= b_q >> 1;
			end
			ST_VLOAD: if (count_q <= COUNT_BITS'(1)) var_q <= '0;
			ST_VDIV: if (div_sts.done) begin
				var_q <= (div_quo[DIV_NUM_W-1:VAR_W] != '0) ? '1 : div_quo[VAR_W-1:0];
			end
			ST_SLOAD: begin
				rad_q  <= {var_q, 8'b0};
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= sq_fit ? (rem_t - trial) : rem_t;
				root_q <= {root_q[ROOT_W-2:0], sq_fit};
			end
			ST_OUT: if (out_load) begin
				sample_count    <= 24'(count_q);
				running_mean    <= 32'(mean_q);
				sample_variance <= var_q;
				std_deviation   <= root_q;
				minimum         <= min_q;
				maximum         <= max_q;
				saturated       <= sat_q;
			end
			default: ;
		endcase
	end

	`include "assert_macros.svh"

	`ASSERT_IMP(a_idle_div_free, clk, arst_n, state_q == ST_IDLE, !div_sts.busy)
	`ASSERT_NXT(a_count_set, clk, arst_n, in_fire, count_q != '0)
	`ASSERT_IMP(a_min_le_max, clk, arst_n, count_q != '0, min_q <= max_q)
	`ASSERT_IMP(a_sat_full, clk, arst_n, state_q == ST_OUT && sat_q, count_q == '1)

endmodule

// File: tb/sv/rmv_stats_checker.sv
// Checker for the running statistics block: predicts each word and compares outputs
`timescale 1ns / 100ps

module rmv_stats_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] sample,
	input  logic               restart,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [23:0]        sample_count,
	input  logic signed [31:0] running_mean,
	input  logic [39:0]        sample_variance,
	input  logic [23:0]        std_deviation,
	input  logic signed [15:0] minimum,
	input  logic signed [15:0] maximum,
	input  logic               saturated,
	output int                 pending,
	output int                 fail_count
);

	localparam logic [63:0] COUNT_FULL = 64'hFF_FFFF;
	localparam logic [63:0] VAR_MAX    = 64'hFF_FFFF_FFFF;

	typedef struct packed {
		logic [23:0] cnt;
		logic [31:0] mean;
		logic [39:0] var_q8;
		logic [23:0] root;
		logic [15:0] lo;
		logic [15:0] hi;
		logic        sat;
	} stats_t;

	stats_t      stats_q[$];
	logic [63:0] n_seen;
	longint      mean_acc;
	logic [63:0] dev_sum;
	int          low_seen;
	int          high_seen;

	function automatic logic [63:0] abs64(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Fold one sample into the running statistics and return the expected word
	function automatic stats_t fold_sample(logic signed [15:0] s, logic rs);
		stats_t       r;
		int           x;
		longint       bx;
		longint       d_old;
		longint       d_new;
		logic [63:0]  q;
		logic [127:0] prod_full;
		logic [63:0]  prod;
		logic [64:0]  sum_ext;
		logic [63:0]  var_q8;
		logic [63:0]  root_full;
		x      = s;
		bx     = longint'(x) * 65536;
		r.sat  = 1'b0;
		if (rs || n_seen == 0) begin
			n_seen    = 1;
			mean_acc  = bx;
			dev_sum   = 0;
			low_seen  = x;
			high_seen = x;
		end else if (n_seen >= COUNT_FULL) begin
			r.sat = 1'b1;
		end else begin
			n_seen    = n_seen + 1;
			d_old     = bx - mean_acc;
			q         = abs64(d_old) / n_seen;
			mean_acc  = (d_old < 0) ? mean_acc - longint'(q) : mean_acc + longint'(q);
			d_new     = bx - mean_acc;
			prod_full = 128'(abs64(d_old)) * 128'(abs64(d_new));
			prod_full = prod_full >> 24;
			prod      = (prod_full[127:64] != 0) ? '1 : prod_full[63:0];
			sum_ext   = 65'(dev_sum) + 65'(prod);
			dev_sum   = sum_ext[64] ? '1 : sum_ext[63:0];
			if (x < low_seen)
				low_seen = x;
			if (x > high_seen)
				high_seen = x;
		end
		var_q8 = 0;
		if (n_seen > 1) begin
			var_q8 = dev_sum / (n_seen - 1);
			if (var_q8 > VAR_MAX)
				var_q8 = VAR_MAX;
		end
		root_full = int_sqrt(var_q8 << 8);
		r.cnt    = n_seen[23:0];
		r.mean   = mean_acc[31:0];
		r.var_q8 = var_q8[39:0];
		r.root   = root_full[23:0];
		r.lo     = low_seen[15:0];
		r.hi     = high_seen[15:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stats_t e;
		if (!arst_n) begin
			n_seen     = 0;
			mean_acc   = 0;
			dev_sum    = 0;
			low_seen   = 0;
			high_seen  = 0;
			fail_count = 0;
			pending    = 0;
			stats_q.delete();
		end else begin
			if (in_valid && in_ready)
				stats_q = {stats_q, fold_sample(sample, restart)};
			if (out_valid && out_ready) begin
				if (stats_q.size() == 0) begin
					$display("%0t: unexpected word, count %h", $time, sample_count);
					fail_count++;
				end else begin
					e = stats_q.pop_front();
					check_field("sample_count", {40'd0, e.cnt}, {40'd0, sample_count});
					check_field("running_mean", {32'd0, e.mean}, {32'd0, running_mean});
					check_field("sample_variance", {24'd0, e.var_q8},
						{24'd0, sample_variance});
					check_field("std_deviation", {40'd0, e.root}, {40'd0, std_deviation});
					check_field("minimum", {48'd0, e.lo}, {48'd0, minimum});
					check_field("maximum", {48'd0, e.hi}, {48'd0, maximum});
					check_field("saturated", {63'd0, e.sat}, {63'd0, saturated});
				end
			end
			pending = stats_q.size();
		end
	end

endmodule

// File: tb/sv/tb_running_mean_variance_minmax.sv
// Testbench top: drives samples, random backpressure, and reports the verdict
`timescale 1ns / 100ps

module tb_running_mean_variance_minmax import rmv_pkg::*;;

	localparam int CYCLE_LIMIT = 2_000_000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] sample;
	logic               restart;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [23:0]        sample_count;
	logic signed [31:0] running_mean;
	logic [VAR_W-1:0]   sample_variance;
	logic [ROOT_W-1:0]  std_deviation;
	logic signed [15:0] minimum;
	logic signed [15:0] maximum;
	logic               saturated;
	int                 pending;
	int                 fail_count;
	int                 cycle_cnt = 0;
	logic               steady;

	running_mean_variance_minmax dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .restart(restart),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_count(sample_count), .running_mean(running_mean),
		.sample_variance(sample_variance), .std_deviation(std_deviation),
		.minimum(minimum), .maximum(maximum), .saturated(saturated)
	);

	rmv_stats_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .restart(restart),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_count(sample_count), .running_mean(running_mean),
		.sample_variance(sample_variance), .std_deviation(std_deviation),
		.minimum(minimum), .maximum(maximum), .saturated(saturated),
		.pending(pending), .fail_count(fail_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (steady)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(99) >= 34);
	end

	// Hold one word on the channel until the block takes it
	task automatic send_word(logic signed [15:0] s, logic rs);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 34)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		restart  <= rs;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int run_len;
		int n;
		steady    = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		sample    = '0;
		restart   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first word after reset counts as a restart even with restart low
		send_word(16'sh7FFF, 1'b0);
		send_word(-16'sd32768, 1'b0);
		send_word(16'sh7FFF, 1'b0);
		send_word(-16'sd32768, 1'b0);
		send_word(16'sd0, 1'b0);
		send_word(-16'sd32768, 1'b1);
		send_word(-16'sd32768, 1'b0);
		send_word(16'sh7FFF, 1'b0);
		send_word(16'sd0, 1'b1);
		send_word(16'sd1, 1'b0);
		send_word(-16'sd1, 1'b0);
		send_word(16'sd0, 1'b0);
		send_word(16'sh5555, 1'b1);
		send_word(16'shAAAA, 1'b0);
		send_word(16'sh7FFF, 1'b1);
		send_word(16'sh7FFF, 1'b0);
		send_word(16'sh7FFF, 1'b0);
		drain();

		n = 0;
		while (n < 1300) begin
			steady  = (n >= 500 && n < 700);
			run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
			send_word(16'($urandom), 1'b1);
			n++;
			for (int i = 1; i < run_len && n < 1300; i++) begin
				send_word(pick_sample(), ($urandom_range(49) == 0));
				n++;
			end
			if (n > 300 && n < 340)
				drain();
		end
		steady = 1'b0;
		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
